>>> sv/tfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tfb_pkg;

	localparam int MaxCells = 4096;
	localparam int LenW = 13;
	localparam int LenFieldMax = 8191;
	localparam int LenHiRaw = 83 + MaxCells;
	localparam logic [LenW-1:0] LEN_MIN = LenW'(84);
	localparam logic [LenW-1:0] LEN_MAX =
		LenW'((LenHiRaw > LenFieldMax) ? LenFieldMax : LenHiRaw);
	localparam logic [LenW-1:0] LEN_RESET = LenW'(84);

	localparam logic [7:0] MAGIC_0 = 8'hC3;
	localparam logic [7:0] MAGIC_1 = 8'h3C;
	localparam logic [7:0] VERSION = 8'h01;
	localparam logic [7:0] FRAME_TYPE = 8'h01;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef struct packed {
		logic [7:0]      data;
		logic            first;
		logic            last;
		logic [LenW-1:0] len;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} qhead_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} qpush_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> sv/tfb_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tfb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	modport source (output valid, output payload_byte, input ready);
	modport sink (input valid, input payload_byte, output ready);
endinterface

interface tfb_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	modport source (output valid, output out_byte, output frame_end, input ready);
	modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface
`default_nettype wire

>>> sv/tfb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tfb_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [tfb_pkg::LenW-1:0] cfg_wdata,
	tfb_byte_if.sink                    payload_in,
	input  wire logic                   q_full,
	output tfb_pkg::qpush_t             qpush
);

	logic [tfb_pkg::LenW-1:0] len_q;
	logic [tfb_pkg::LenW-1:0] count_q;
	logic [tfb_pkg::LenW-1:0] eff_len;
	logic [tfb_pkg::LenW:0]   count_inc;
	logic                     last;
	logic                     accept;

	always_comb begin
		if (len_q < tfb_pkg::LEN_MIN) begin
			eff_len = tfb_pkg::LEN_MIN;
		end else if (len_q > tfb_pkg::LEN_MAX) begin
			eff_len = tfb_pkg::LEN_MAX;
		end else begin
			eff_len = len_q;
		end
	end

	assign count_inc = {1'b0, count_q} + 1'b1;
	assign last = count_inc >= {1'b0, eff_len};
	assign payload_in.ready = !q_full;
	assign accept = payload_in.valid && !q_full;

	assign qpush.push = accept;
	assign qpush.entry.data = payload_in.payload_byte;
	assign qpush.entry.first = (count_q == '0);
	assign qpush.entry.last = last;
	assign qpush.entry.len = eff_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= tfb_pkg::LEN_RESET;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (accept) begin
				count_q <= last ? '0 : count_inc[tfb_pkg::LenW-1:0];
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/tfb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module tfb_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tfb_pkg::qpush_t qpush,
	input  wire logic            pop,
	output logic                 full,
	output tfb_pkg::qhead_t      head
);

	tfb_pkg::entry_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	assign full = cnt_q[1];
	assign head.valid = (cnt_q != 2'd0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (qpush.push) begin
			mem_q[wr_ptr_q] <= qpush.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (qpush.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({qpush.push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/tfb_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tfb_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tfb_pkg::qhead_t head,
	output logic                 pop,
	tfb_frame_if.source          frame_out
);

	typedef enum logic [3:0] {
		POS_MAGIC0, POS_MAGIC1, POS_VER, POS_TYPE, POS_SEQ_LO, POS_SEQ_HI,
		POS_LEN_LO, POS_LEN_HI, POS_PAYLOAD, POS_CRC_LO, POS_CRC_HI
	} pos_t;

	pos_t        pos_q;
	logic        busy_q;
	logic [15:0] crc_q;
	logic [15:0] seq_q;
	logic        ov_q;
	logic [7:0]  byte_q;
	logic        end_q;

	pos_t        cur_pos;
	pos_t        nxt_pos;
	logic        step;
	logic [7:0]  cur_byte;
	logic        feed;
	logic [15:0] crc_base;
	logic [15:0] len16;

	assign step = head.valid && (!ov_q || frame_out.ready);
	assign cur_pos = busy_q ? pos_q : (head.entry.first ? POS_MAGIC0 : POS_PAYLOAD);
	assign crc_base = (cur_pos == POS_MAGIC0) ? tfb_pkg::CRC_INIT : crc_q;
	assign len16 = {{(16 - tfb_pkg::LenW){1'b0}}, head.entry.len};

	always_comb begin
		cur_byte = head.entry.data;
		feed = 1'b1;
		nxt_pos = POS_PAYLOAD;
		pop = 1'b0;
		case (cur_pos)
			POS_MAGIC0: begin
				cur_byte = tfb_pkg::MAGIC_0;
				nxt_pos = POS_MAGIC1;
			end
			POS_MAGIC1: begin
				cur_byte = tfb_pkg::MAGIC_1;
				nxt_pos = POS_VER;
			end
			POS_VER: begin
				cur_byte = tfb_pkg::VERSION;
				nxt_pos = POS_TYPE;
			end
			POS_TYPE: begin
				cur_byte = tfb_pkg::FRAME_TYPE;
				nxt_pos = POS_SEQ_LO;
			end
			POS_SEQ_LO: begin
				cur_byte = seq_q[7:0];
				nxt_pos = POS_SEQ_HI;
			end
			POS_SEQ_HI: begin
				cur_byte = seq_q[15:8];
				nxt_pos = POS_LEN_LO;
			end
			POS_LEN_LO: begin
				cur_byte = len16[7:0];
				nxt_pos = POS_LEN_HI;
			end
			POS_LEN_HI: begin
				cur_byte = len16[15:8];
				nxt_pos = POS_PAYLOAD;
			end
			POS_PAYLOAD: begin
				cur_byte = head.entry.data;
				nxt_pos = POS_CRC_LO;
				pop = step && !head.entry.last;
			end
			POS_CRC_LO: begin
				cur_byte = crc_q[7:0];
				feed = 1'b0;
				nxt_pos = POS_CRC_HI;
			end
			POS_CRC_HI: begin
				cur_byte = crc_q[15:8];
				feed = 1'b0;
				nxt_pos = POS_PAYLOAD;
				pop = step;
			end
			default: begin
				cur_byte = head.entry.data;
				feed = 1'b0;
				nxt_pos = POS_PAYLOAD;
			end
		endcase
	end

	assign frame_out.valid = ov_q;
	assign frame_out.out_byte = byte_q;
	assign frame_out.frame_end = end_q;

	always_ff @(posedge clk) begin
		if (step) begin
			byte_q <= cur_byte;
			end_q <= (cur_pos == POS_CRC_HI);
			if (feed) begin
				crc_q <= tfb_pkg::crc_feed(crc_base, cur_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_PAYLOAD;
			busy_q <= 1'b0;
			seq_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (step) begin
				ov_q <= 1'b1;
				pos_q <= nxt_pos;
				busy_q <= !pop;
				if (cur_pos == POS_CRC_HI) begin
					seq_q <= seq_q + 16'd1;
				end
			end else if (frame_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/telemetry_frame_builder_crc16.sv
// channel     dir  payload                    handshake
// payload_in  in   payload_byte[7:0]          valid & ready
// frame_out   out  out_byte[7:0], frame_end   valid & ready
// cfg         in   cfg_wdata[12:0]            cfg_we
//
// One output byte per cycle unless frame_out stalls or the queue is empty;
// header leads each frame, CRC ends it; all pass the single output register.
// A 2-entry queue parts the input classifier from the byte sequencer.
// arst_n clears counters, sequence number and the length register (84).
// Input stalls only on a full queue; it fills as header and CRC bytes go out.
`timescale 1ns / 1ps
`default_nettype none
module telemetry_frame_builder_crc16 (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [tfb_pkg::LenW-1:0] cfg_wdata,
	tfb_byte_if.sink                      payload_in,
	tfb_frame_if.source                   frame_out
);

	tfb_pkg::qpush_t qpush;
	tfb_pkg::qhead_t head;
	logic            q_full;
	logic            pop;

	tfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.payload_in (payload_in),
		.q_full     (q_full),
		.qpush      (qpush)
	);

	tfb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qpush  (qpush),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	tfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.frame_out (frame_out)
	);

endmodule
`default_nettype wire
